### rtl/core/blg_pkg.sv
// Shared types and constants of the battery level gauge.
package blg_pkg;

  localparam int unsigned NumW = 10;
  localparam int unsigned DenW = 6;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned LvlW = 7;

  localparam logic [15:0] MvFull  = 16'd4200;
  localparam logic [15:0] MvKnee1 = 16'd4000;
  localparam logic [15:0] MvKnee2 = 16'd3800;
  localparam logic [15:0] MvKnee3 = 16'd3700;
  localparam logic [15:0] MvKnee4 = 16'd3500;
  localparam logic [15:0] MvEmpty = 16'd3300;

  localparam logic [LvlW-1:0] PctFull  = 7'd100;
  localparam logic [LvlW-1:0] PctKnee1 = 7'd75;
  localparam logic [LvlW-1:0] PctKnee2 = 7'd50;
  localparam logic [LvlW-1:0] PctKnee3 = 7'd25;
  localparam logic [LvlW-1:0] PctKnee4 = 7'd10;
  localparam logic [LvlW-1:0] PctEmpty = 7'd0;

  // Divisors that turn a millivolt offset into whole percent per segment.
  localparam logic [DenW-1:0] DenSteep = 6'd8;
  localparam logic [DenW-1:0] DenMid   = 6'd4;
  localparam logic [DenW-1:0] DenKnee4 = 6'd40;
  localparam logic [DenW-1:0] DenEmpty = 6'd20;

  localparam logic [1:0] RegLow      = 2'd0;
  localparam logic [1:0] RegCritical = 2'd1;
  localparam logic [1:0] RegThresh   = 2'd2;

  localparam logic [1:0] ClsGood     = 2'd0;
  localparam logic [1:0] ClsLow      = 2'd1;
  localparam logic [1:0] ClsCritical = 2'd2;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } blg_div_req_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } blg_state_e;

endpackage

### rtl/core/blg_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module blg_sdiv
  import blg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blg_div_req_t       req_i,
  output logic               done_o,
  output logic [NumW-1:0]    quo_o
);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   part;
  logic            fits;

  always_comb begin
    part  = {rem_q, quo_q[NumW-1]};
    fits  = part >= {1'b0, den_q};
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], fits};
      rem_d = fits ? DenW'(part - {1'b0, den_q}) : part[DenW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/battery_level_gauge.sv
// Top level of the battery level gauge: stream ports, registers and level tracking.
// Each input transfer is either a voltage sample or a power presence update, and
// each gives exactly one output transfer. The curve segment of a sample is picked
// combinationally as the transfer is accepted. Its result passes through the bit-serial
// divider, which scales the millivolt offset to whole percent, then the divider's
// registered done flag, which moves the control to its done state, and then the update
// of the held level and the load of the output register. A power update goes straight
// to the done state and then loads the output register. One item is in work at a
// time, so a new sample or power update is accepted only after the previous item
// has finished. The next item is accepted while the previous result still waits in
// the output register. An item that finishes while the output register is still
// full stalls until that result is taken.
module battery_level_gauge
  import blg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sample_mv, [16] vbus_present, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] raw_level, [13:7] reported_level, [14] level_valid, [15] report_now,
  // [17:16] charge_class, [18] charging, [19] is_low, [23:20] zero
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  blg_state_e      state_q, state_d;
  logic [LvlW-1:0] low_q, crit_q, thresh_q;
  logic            vbus_now_q, vbus_seen_q, held_valid_q, sent_valid_q;
  logic [LvlW-1:0] held_q, sent_q;
  logic            action_q, present_q;
  logic [LvlW-1:0] base_q, base_d;
  logic [NumW-1:0] num_d;
  logic [DenW-1:0] den_d;
  logic [7:0]      ofs;
  logic [15:0]     mv;
  logic            out_valid_q;
  logic [23:0]     out_data_q;
  blg_div_req_t    div_req;
  logic            div_done;
  logic [NumW-1:0] div_quo;
  logic            in_xfer, out_free, finish;

  logic            vbus_now_d, vbus_seen_d, held_valid_d, sent_valid_d, report;
  logic [LvlW-1:0] held_d, sent_d, raw, diff;
  logic [1:0]      cls;
  logic            low;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      RegLow:      prdata = {25'd0, low_q};
      RegCritical: prdata = {25'd0, crit_q};
      RegThresh:   prdata = {25'd0, thresh_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= 7'd20;
      crit_q   <= 7'd5;
      thresh_q <= 7'd5;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegLow:      low_q    <= pwdata[LvlW-1:0];
        RegCritical: crit_q   <= pwdata[LvlW-1:0];
        RegThresh:   thresh_q <= pwdata[LvlW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = (state_q == StDone) && out_free;
  assign mv            = s_axis_tdata[15:0];

  // Pick the curve segment and the offset into it.
  always_comb begin
    base_d = PctEmpty;
    ofs    = '0;
    den_d  = DenSteep;
    priority if (mv >= MvFull) begin
      base_d = PctFull;
    end else if (mv >= MvKnee1) begin
      base_d = PctKnee1;
      ofs    = 8'(mv - MvKnee1);
    end else if (mv >= MvKnee2) begin
      base_d = PctKnee2;
      ofs    = 8'(mv - MvKnee2);
    end else if (mv >= MvKnee3) begin
      base_d = PctKnee3;
      ofs    = 8'(mv - MvKnee3);
      den_d  = DenMid;
    end else if (mv >= MvKnee4) begin
      base_d = PctKnee4;
      ofs    = 8'(mv - MvKnee4);
      den_d  = DenKnee4;
    end else if (mv >= MvEmpty) begin
      ofs    = 8'(mv - MvEmpty);
      den_d  = DenEmpty;
    end else begin
      base_d = PctEmpty;
    end
    num_d = (den_d == DenKnee4) ? (NumW'(ofs) + {1'b0, ofs, 1'b0}) : NumW'(ofs);
  end

  assign div_req.start = in_xfer && !s_axis_tuser[0];
  assign div_req.num   = num_d;
  assign div_req.den   = den_d;

  blg_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_xfer) state_d = s_axis_tuser[0] ? StDone : StDiv;
      StDiv:  if (div_done) state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Level tracking for the item that finishes now.
  always_comb begin
    vbus_now_d   = vbus_now_q;
    vbus_seen_d  = vbus_seen_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    sent_d       = sent_q;
    sent_valid_d = sent_valid_q;
    report       = 1'b0;
    raw          = '0;
    diff         = '0;
    if (action_q) begin
      vbus_now_d = present_q;
      if (present_q) vbus_seen_d = 1'b1;
    end else begin
      raw = base_q + div_quo[LvlW-1:0];
      if (vbus_now_q || vbus_seen_q || !held_valid_q) begin
        held_d       = raw;
        held_valid_d = 1'b1;
        vbus_seen_d  = 1'b0;
      end else if (raw < held_q) begin
        held_d = raw;
      end
      diff = (held_d >= sent_q) ? held_d - sent_q : sent_q - held_d;
      if (!sent_valid_q || diff >= thresh_q) begin
        sent_d       = held_d;
        sent_valid_d = 1'b1;
        report       = 1'b1;
      end
    end
    cls = ClsGood;
    low = 1'b0;
    if (held_valid_d) begin
      if (held_d <= crit_q) cls = ClsCritical;
      else if (held_d <= low_q) cls = ClsLow;
      low = (held_d <= low_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      vbus_now_q   <= 1'b0;
      vbus_seen_q  <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      sent_q       <= '0;
      sent_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        vbus_now_q   <= vbus_now_d;
        vbus_seen_q  <= vbus_seen_d;
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
        sent_q       <= sent_d;
        sent_valid_q <= sent_valid_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q  <= s_axis_tuser[0];
      present_q <= s_axis_tdata[16];
      base_q    <= base_d;
    end
    if (finish) begin
      out_data_q <= {4'd0, low, vbus_now_d, cls, report, held_valid_d, held_d, raw};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
